>>> sv/assert_macros.svh
// assertion macros shared by the svpu rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SVPU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SVPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SVPU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/svpu_pkg.sv
`timescale 1ns / 1ps
// svpu_pkg: widths, config register codes, word types and saturation helpers
// no dependencies
package svpu_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int WORD_BITS      = 32;
    localparam int RAND_BITS      = 16;
    localparam int GAIN_BITS      = 20;
    localparam int LIMIT_BITS     = 31;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LONG_BITS      = GAIN_BITS + 1 + WORD_BITS;
    localparam int RPROD_BITS     = RAND_BITS + 1 + WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [RAND_BITS-1:0]        rand_t;
    typedef logic [GAIN_BITS-1:0]        gain_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_INERTIA,
        REG_COGNITIVE,
        REG_SOCIAL,
        REG_VLIMIT,
        REG_FLOOR,
        REG_CEILING
    } cfg_reg_t;

    typedef struct packed {
        gain_t                 inertia_weight;
        gain_t                 cognitive_gain;
        gain_t                 social_gain;
        logic [LIMIT_BITS-1:0] velocity_limit;
        word_t                 position_floor;
        word_t                 position_ceiling;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        inertia_weight:   20'd47841,
        cognitive_gain:   20'd98304,
        social_gain:      20'd98304,
        velocity_limit:   31'd65536,
        position_floor:   -32'sd327680,
        position_ceiling: 32'sd327680
    };

    // front half to back half
    typedef struct packed {
        word_t position;
        word_t t0;
        word_t t1;
        word_t t2;
        logic  vflag;
        logic  last;
    } mid_word_t;

    typedef struct packed {
        word_t value;
        logic  sat;
    } sat_word_t;

    // saturate a sum or difference one bit wider than a word
    function automatic sat_word_t sat_sum(input logic [WORD_BITS:0] s);
        sat_word_t r;
        if (s[WORD_BITS] != s[WORD_BITS-1])
        begin
            r.value = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = s[WORD_BITS-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    // saturate a shifted product to a word
    function automatic sat_word_t sat_long(input logic signed [LONG_BITS-1:0] v);
        sat_word_t r;
        logic      all_ones;
        logic      all_zeros;
        all_ones  = &v[LONG_BITS-1:WORD_BITS-1];
        all_zeros = ~(|v[LONG_BITS-1:WORD_BITS-1]);
        if (all_ones || all_zeros)
        begin
            r.value = v[WORD_BITS-1:0];
            r.sat   = 1'b0;
        end
        else
        begin
            r.value = v[LONG_BITS-1] ? WORD_MIN : WORD_MAX;
            r.sat   = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> sv/svpu_ifs.sv
`timescale 1ns / 1ps
// svpu channel interfaces: input word, result word and config write
// depends on svpu_pkg
interface svpu_item_if
    import svpu_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t position;
    word_t velocity;
    word_t personal_best;
    word_t global_best;
    rand_t rand_cognitive;
    rand_t rand_social;
    logic  last_element;

    modport source (
        output valid, position, velocity, personal_best, global_best,
               rand_cognitive, rand_social, last_element,
        input  ready
    );
    modport sink (
        input  valid, position, velocity, personal_best, global_best,
               rand_cognitive, rand_social, last_element,
        output ready
    );
endinterface

interface svpu_result_if
    import svpu_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t new_velocity;
    word_t new_position;
    logic  velocity_clamped;
    logic  position_clamped;
    logic  last_out;

    modport source (
        output valid, new_velocity, new_position, velocity_clamped,
               position_clamped, last_out,
        input  ready
    );
    modport sink (
        input  valid, new_velocity, new_position, velocity_clamped,
               position_clamped, last_out,
        output ready
    );
endinterface

interface svpu_cfg_if
    import svpu_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [WORD_BITS-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/svpu_front.sv
`timescale 1ns / 1ps
// svpu_front: best-minus-position differences, gain products, random products
// three register stages; depends on svpu_pkg, svpu_ifs, assert_macros.svh
`include "assert_macros.svh"

module svpu_front
    import svpu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    svpu_item_if.sink        item,
    output logic             mid_valid,
    input  logic             mid_ready,
    output mid_word_t        mid
);

    typedef struct packed {
        word_t position;
        word_t velocity;
        word_t diff_p;
        word_t diff_g;
        rand_t r_cog;
        rand_t r_soc;
        logic  vflag;
        logic  last;
    } s1_t;

    typedef struct packed {
        word_t position;
        word_t t0;
        word_t m1;
        word_t m2;
        rand_t r_cog;
        rand_t r_soc;
        logic  vflag;
        logic  last;
    } s2_t;

    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    mid_word_t s3_reg, s3_next;
    logic      valid1_reg, valid1_next;
    logic      valid2_reg, valid2_next;
    logic      valid3_reg, valid3_next;
    logic      rdy1, rdy2, rdy3;

    sat_word_t                     dp, dg, sw, sc, ss, sr1, sr2;
    logic signed [LONG_BITS-1:0]   prod_w, prod_c, prod_s;
    logic signed [RPROD_BITS-1:0]  prod_r1, prod_r2;

    // bubble-collapsing handshake
    assign rdy3       = !valid3_reg || mid_ready;
    assign rdy2       = !valid2_reg || rdy3;
    assign rdy1       = !valid1_reg || rdy2;
    assign item.ready = rdy1;

    assign valid1_next = rdy1 ? item.valid : valid1_reg;
    assign valid2_next = rdy2 ? valid1_reg : valid2_reg;
    assign valid3_next = rdy3 ? valid2_reg : valid3_reg;

    // stage 1: differences
    always_comb
    begin
        dp = sat_sum({item.personal_best[WORD_BITS-1], item.personal_best}
                     - {item.position[WORD_BITS-1], item.position});
        dg = sat_sum({item.global_best[WORD_BITS-1], item.global_best}
                     - {item.position[WORD_BITS-1], item.position});
        s1_next.position = item.position;
        s1_next.velocity = item.velocity;
        s1_next.diff_p   = dp.value;
        s1_next.diff_g   = dg.value;
        s1_next.r_cog    = item.rand_cognitive;
        s1_next.r_soc    = item.rand_social;
        s1_next.vflag    = dp.sat | dg.sat;
        s1_next.last     = item.last_element;
    end

    // stage 2: gain products
    always_comb
    begin
        prod_w = $signed({1'b0, cfg.inertia_weight}) * $signed(s1_reg.velocity);
        prod_c = $signed({1'b0, cfg.cognitive_gain}) * $signed(s1_reg.diff_p);
        prod_s = $signed({1'b0, cfg.social_gain}) * $signed(s1_reg.diff_g);
        sw     = sat_long(prod_w >>> FRAC_BITS);
        sc     = sat_long(prod_c >>> FRAC_BITS);
        ss     = sat_long(prod_s >>> FRAC_BITS);
        s2_next.position = s1_reg.position;
        s2_next.t0       = sw.value;
        s2_next.m1       = sc.value;
        s2_next.m2       = ss.value;
        s2_next.r_cog    = s1_reg.r_cog;
        s2_next.r_soc    = s1_reg.r_soc;
        s2_next.vflag    = s1_reg.vflag | sw.sat | sc.sat | ss.sat;
        s2_next.last     = s1_reg.last;
    end

    // stage 3: random fraction products
    always_comb
    begin
        prod_r1 = $signed({1'b0, s2_reg.r_cog}) * $signed(s2_reg.m1);
        prod_r2 = $signed({1'b0, s2_reg.r_soc}) * $signed(s2_reg.m2);
        sr1     = sat_long(LONG_BITS'(prod_r1 >>> RAND_BITS));
        sr2     = sat_long(LONG_BITS'(prod_r2 >>> RAND_BITS));
        s3_next.position = s2_reg.position;
        s3_next.t0       = s2_reg.t0;
        s3_next.t1       = sr1.value;
        s3_next.t2       = sr2.value;
        s3_next.vflag    = s2_reg.vflag | sr1.sat | sr2.sat;
        s3_next.last     = s2_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
            valid3_reg <= valid3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign mid_valid = valid3_reg;
    assign mid       = s3_reg;

    `SVPU_ASSERT_IMP(a_front_full, clk, rst_n, !item.ready, valid1_reg && valid2_reg && valid3_reg, "front stalled with a bubble")
    `SVPU_ASSERT_NXT(a_front_hold1, clk, rst_n, valid1_reg && !rdy2, valid1_reg, "stage 1 word lost")
    `SVPU_ASSERT_NXT(a_front_hold2, clk, rst_n, valid2_reg && !rdy3, valid2_reg, "stage 2 word lost")

endmodule

>>> sv/svpu_back.sv
`timescale 1ns / 1ps
// svpu_back: velocity sums and limit clamp, position sum and bound clamp
// three register stages, last one drives the result; depends on svpu_pkg, svpu_ifs, assert_macros.svh
`include "assert_macros.svh"

module svpu_back
    import svpu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          mid_valid,
    output logic          mid_ready,
    input  mid_word_t     mid,
    svpu_result_if.source result
);

    typedef struct packed {
        word_t position;
        word_t partial;
        word_t t2;
        logic  vflag;
        logic  last;
    } s4_t;

    typedef struct packed {
        word_t position;
        word_t nv;
        logic  vflag;
        logic  last;
    } s5_t;

    typedef struct packed {
        word_t nv;
        word_t np;
        logic  vflag;
        logic  pflag;
        logic  last;
    } s6_t;

    s4_t       s4_reg, s4_next;
    s5_t       s5_reg, s5_next;
    s6_t       s6_reg, s6_next;
    logic      valid4_reg, valid4_next;
    logic      valid5_reg, valid5_next;
    logic      valid6_reg, valid6_next;
    logic      rdy4, rdy5, rdy6;
    sat_word_t sum01, sum_v, sum_p;
    word_t     vmax, vmin;

    assign rdy6      = !valid6_reg || result.ready;
    assign rdy5      = !valid5_reg || rdy6;
    assign rdy4      = !valid4_reg || rdy5;
    assign mid_ready = rdy4;

    assign valid4_next = rdy4 ? mid_valid : valid4_reg;
    assign valid5_next = rdy5 ? valid4_reg : valid5_reg;
    assign valid6_next = rdy6 ? valid5_reg : valid6_reg;

    // stage 4: inertia plus cognitive term
    always_comb
    begin
        sum01 = sat_sum({mid.t0[WORD_BITS-1], mid.t0} + {mid.t1[WORD_BITS-1], mid.t1});
        s4_next.position = mid.position;
        s4_next.partial  = sum01.value;
        s4_next.t2       = mid.t2;
        s4_next.vflag    = mid.vflag | sum01.sat;
        s4_next.last     = mid.last;
    end

    // stage 5: social term and velocity limit
    always_comb
    begin
        vmax  = {1'b0, cfg.velocity_limit};
        vmin  = -vmax;
        sum_v = sat_sum({s4_reg.partial[WORD_BITS-1], s4_reg.partial}
                        + {s4_reg.t2[WORD_BITS-1], s4_reg.t2});
        s5_next.position = s4_reg.position;
        s5_next.vflag    = s4_reg.vflag | sum_v.sat;
        s5_next.last     = s4_reg.last;
        s5_next.nv       = sum_v.value;
        if ($signed(sum_v.value) > $signed(vmax))
        begin
            s5_next.nv    = vmax;
            s5_next.vflag = 1'b1;
        end
        else if ($signed(sum_v.value) < $signed(vmin))
        begin
            s5_next.nv    = vmin;
            s5_next.vflag = 1'b1;
        end
    end

    // stage 6: position update, ceiling checked before floor
    always_comb
    begin
        sum_p = sat_sum({s5_reg.position[WORD_BITS-1], s5_reg.position}
                        + {s5_reg.nv[WORD_BITS-1], s5_reg.nv});
        s6_next.nv    = s5_reg.nv;
        s6_next.vflag = s5_reg.vflag;
        s6_next.last  = s5_reg.last;
        s6_next.np    = sum_p.value;
        s6_next.pflag = sum_p.sat;
        if ($signed(sum_p.value) > $signed(cfg.position_ceiling))
        begin
            s6_next.np    = cfg.position_ceiling;
            s6_next.pflag = 1'b1;
        end
        else if ($signed(sum_p.value) < $signed(cfg.position_floor))
        begin
            s6_next.np    = cfg.position_floor;
            s6_next.pflag = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
        end
        else
        begin
            valid4_reg <= valid4_next;
            valid5_reg <= valid5_next;
            valid6_reg <= valid6_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_reg <= s4_next;
        end
        if (rdy5)
        begin
            s5_reg <= s5_next;
        end
        if (rdy6)
        begin
            s6_reg <= s6_next;
        end
    end

    assign result.valid            = valid6_reg;
    assign result.new_velocity     = s6_reg.nv;
    assign result.new_position     = s6_reg.np;
    assign result.velocity_clamped = s6_reg.vflag;
    assign result.position_clamped = s6_reg.pflag;
    assign result.last_out         = s6_reg.last;

    `SVPU_ASSERT_IMP(a_back_full, clk, rst_n, !mid_ready, valid4_reg && valid5_reg && valid6_reg, "back stalled with a bubble")
    `SVPU_ASSERT_NXT(a_back_hold4, clk, rst_n, valid4_reg && !rdy5, valid4_reg, "stage 4 word lost")
    `SVPU_ASSERT_NXT(a_back_hold5, clk, rst_n, valid5_reg && !rdy6, valid5_reg, "stage 5 word lost")

endmodule

>>> sv/swarm_velocity_position_update_top.sv
`timescale 1ns / 1ps
// particle swarm velocity and position update, one dimension per word
// depends on svpu_pkg, svpu_ifs, svpu_front, svpu_back
//
// channels: item (sink) takes position, velocity, personal and global best,
// two Q0.16 random fractions and an end-of-sweep mark; result (source) gives
// the clamped new velocity and position, two clamp flags and the mark.
// cfg (sink) writes gains, velocity limit and position bounds by index;
// it is always ready and should be written only while the pipeline is empty.
// throughput: one word per cycle while the receiver is ready, set by six
// register stages (differences, gain multipliers, random multipliers, two
// velocity adds, position add) that carry an item word to its result word.
// each stage has its own valid bit and moves on when the next one is free,
// so bubbles close up; a stalled receiver fills the pipeline, and item.ready
// drops only when all six stages hold words. nothing is lost or repeated.
// reset clears all valid bits and loads the config registers' defaults.

module swarm_velocity_position_update_top
    import svpu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    svpu_item_if.sink     item,
    svpu_result_if.source result,
    svpu_cfg_if.sink      cfg
);

    cfg_t      cfg_reg, cfg_next;
    logic      mid_valid;
    logic      mid_ready;
    mid_word_t mid;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_INERTIA:   cfg_next.inertia_weight   = cfg.data[GAIN_BITS-1:0];
                REG_COGNITIVE: cfg_next.cognitive_gain   = cfg.data[GAIN_BITS-1:0];
                REG_SOCIAL:    cfg_next.social_gain      = cfg.data[GAIN_BITS-1:0];
                REG_VLIMIT:    cfg_next.velocity_limit   = cfg.data[LIMIT_BITS-1:0];
                REG_FLOOR:     cfg_next.position_floor   = cfg.data[WORD_BITS-1:0];
                REG_CEILING:   cfg_next.position_ceiling = cfg.data[WORD_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    svpu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item      (item),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    svpu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .result    (result)
    );

endmodule
